// File: hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types and codes for the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    // operation codes of the input op field
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_FIXED  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_OWNER  = 3'd5;

    // result status codes
    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_NOSPACE   = 3'd1;
    localparam logic [2:0] RES_NOTSTART  = 3'd2;
    localparam logic [2:0] RES_PAGEFREE  = 3'd3;
    localparam logic [2:0] RES_BADCOUNT  = 3'd4;

    // configuration register indexes
    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_FIXED = 2'd2
    } t_pstate;

    typedef struct packed {
        t_pstate      state;
        logic [10:0]  len;
        logic [15:0]  owner;
        logic [19:0]  vpage;
    } t_entry;

    typedef enum logic [3:0] {
        K_INIT,
        K_ALLOC,
        K_BADCNT,
        K_FREE,
        K_FIX,
        K_QUERY,
        K_OWNER,
        K_PGFREE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [10:0]  count;
        logic [9:0]   page;
        logic         make_fixed;
        logic [15:0]  owner;
        logic [19:0]  vpage;
    } t_cmd;

endpackage

`default_nettype wire

// File: hdl/pfa_front.sv
// ----------------------------------------------------------------------------
// Page frame allocator front end
// Accepts operations, classifies them against the map size and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_front
    import pfa_pkg::*;
#(
    parameter int CW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [2:0]    i_op,
    input  wire logic [10:0]   i_count,
    input  wire logic [9:0]    i_page,
    input  wire logic          i_make_fixed,
    input  wire logic [15:0]   i_owner,
    input  wire logic [19:0]   i_vpage,
    input  wire logic [CW-1:0] i_size,
    input  wire logic          i_clearing,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output t_cmd               o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       inmap;
    logic       push;
    logic       pop;

    assign inmap = CW'(i_page) < i_size;

    always_comb begin
        cls.count      = i_count;
        cls.page       = i_page;
        cls.make_fixed = i_make_fixed;
        cls.owner      = i_owner;
        cls.vpage      = i_vpage;
        unique case (i_op)
            OP_INIT:  cls.kind = K_INIT;
            OP_ALLOC: cls.kind = (i_count == 11'd0) ? K_BADCNT : K_ALLOC;
            OP_FREE:  cls.kind = inmap ? K_FREE : K_PGFREE;
            OP_FIXED: cls.kind = inmap ? K_FIX : K_PGFREE;
            OP_QUERY: cls.kind = inmap ? K_QUERY : K_NOP;
            OP_OWNER: cls.kind = inmap ? K_OWNER : K_PGFREE;
            default:  cls.kind = K_NOP;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2) || i_clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_cmd      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: hdl/pfa_back.sv
// ----------------------------------------------------------------------------
// Page frame allocator back end
// Holds the page map memory and carries out queued operations one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_back
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = 1024,
    parameter int CW        = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_size,
    input  wire logic [CW-1:0] i_res,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire t_cmd          i_cmd,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [2:0]         o_status,
    output logic [9:0]         o_start_page,
    output logic [1:0]         o_page_state,
    output logic [15:0]        o_owner_out,
    output logic [19:0]        o_vpage_out,
    output logic [10:0]        o_in_use
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam logic [CW-1:0] NP = CW'(NUM_PAGES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_PAGE,
        S_FREE
    } t_state;

    t_entry        mem [NUM_PAGES];
    t_entry        rd_data;
    logic          we;
    t_entry        wdata;
    logic [PW-1:0] raddr;

    t_state        r_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_didx;
    logic [CW-1:0] r_first;
    logic [CW-1:0] r_last;
    logic [CW-1:0] r_res;
    logic [CW-1:0] r_in_use;
    logic [PW-1:0] r_cursor;
    logic [10:0]   r_run;
    logic [10:0]   r_left;
    logic          r_dv;
    logic          r_pass;
    logic          r_clr_resp;
    t_cmd          r_cmd;
    logic          r_ov;
    logic [2:0]    r_status;
    logic [9:0]    r_start;
    logic [1:0]    r_pstate;
    logic [15:0]   r_oown;
    logic [19:0]   r_ovp;

    logic          pop;
    logic          rd_free;
    logic          iss;
    logic          hit;
    logic          free_done;
    logic [CW-1:0] cur_wide;

    assign pop       = i_q_valid && (r_state == S_IDLE) && !r_ov;
    assign o_q_ready = (r_state == S_IDLE) && !r_ov;
    assign rd_free   = (rd_data.state == ST_FREE);
    assign iss       = r_idx < r_hi;
    assign hit       = r_dv && rd_free && ({1'b0, r_run} + 12'd1 == {1'b0, r_cmd.count});
    assign free_done = (r_left == 11'd0) || (r_idx >= i_size);
    assign cur_wide  = CW'(r_cursor);
    assign o_clearing = (r_state == S_CLEAR) && !r_clr_resp;

    always_comb begin
        we    = 1'b0;
        wdata = '0;
        raddr = PW'(i_cmd.page);
        case (r_state)
            S_CLEAR: begin
                we          = 1'b1;
                wdata.state = (r_idx < r_res) ? ST_FIXED : ST_FREE;
            end
            S_SCAN: begin
                raddr = PW'(r_idx);
            end
            S_MARK: begin
                we          = 1'b1;
                wdata.state = ST_ALLOC;
                wdata.len   = (r_idx == r_first) ? r_cmd.count : 11'd0;
            end
            S_PAGE: begin
                raddr = PW'(r_idx + 1'b1);
                case (r_cmd.kind)
                    K_FREE: begin
                        we = !rd_free && (rd_data.len != 11'd0);
                    end
                    K_FIX: begin
                        we          = !rd_free;
                        wdata       = rd_data;
                        wdata.state = r_cmd.make_fixed ? ST_FIXED : ST_ALLOC;
                    end
                    K_OWNER: begin
                        we          = !rd_free;
                        wdata       = rd_data;
                        wdata.owner = r_cmd.owner;
                        wdata.vpage = r_cmd.vpage;
                    end
                    default: begin
                        we = 1'b0;
                    end
                endcase
            end
            S_FREE: begin
                raddr = PW'(r_idx + 1'b1);
                we    = !free_done && !rd_free;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[PW'(r_idx)] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_res      <= '0;
            r_in_use   <= '0;
            r_cursor   <= '0;
            r_clr_resp <= 1'b0;
            r_ov       <= 1'b0;
            r_dv       <= 1'b0;
            r_pass     <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == NP - 1'b1) begin
                        r_state  <= S_IDLE;
                        r_cursor <= '0;
                        r_in_use <= r_res;
                        r_ov     <= r_clr_resp;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_cmd    <= i_cmd;
                        r_status <= RES_OK;
                        r_start  <= '0;
                        r_pstate <= '0;
                        r_oown   <= '0;
                        r_ovp    <= '0;
                        case (i_cmd.kind)
                            K_INIT: begin
                                r_res      <= i_res;
                                r_idx      <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            K_ALLOC: begin
                                r_idx   <= cur_wide;
                                r_hi    <= i_size;
                                r_pass  <= 1'b0;
                                r_run   <= '0;
                                r_dv    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            K_FREE, K_FIX, K_QUERY, K_OWNER: begin
                                r_idx   <= CW'(i_cmd.page);
                                r_state <= S_PAGE;
                            end
                            K_BADCNT: begin
                                r_status <= RES_BADCOUNT;
                                r_ov     <= 1'b1;
                            end
                            K_PGFREE: begin
                                r_status <= RES_PAGEFREE;
                                r_ov     <= 1'b1;
                            end
                            default: begin
                                r_ov <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_dv) begin
                        r_run <= rd_free ? r_run + 1'b1 : 11'd0;
                    end
                    r_dv   <= iss && !hit;
                    r_didx <= r_idx;
                    if (iss) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit) begin
                        r_first <= r_didx + 1'b1 - CW'(r_cmd.count);
                        r_idx   <= r_didx + 1'b1 - CW'(r_cmd.count);
                        r_last  <= r_didx;
                        r_state <= S_MARK;
                    end else if (!iss && !r_dv) begin
                        if (!r_pass) begin
                            // rescan from page 0 up to the cursor
                            r_pass <= 1'b1;
                            r_idx  <= '0;
                            r_hi   <= (cur_wide < i_size) ? cur_wide : i_size;
                            r_run  <= '0;
                        end else begin
                            r_status <= RES_NOSPACE;
                            r_ov     <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_MARK: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_last) begin
                        r_start  <= 10'(r_first);
                        r_in_use <= r_in_use + CW'(r_cmd.count);
                        r_cursor <= PW'(r_last);
                        r_ov     <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_PAGE: begin
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_cmd.kind)
                        K_FREE: begin
                            if (rd_free) begin
                                r_status <= RES_PAGEFREE;
                            end else if (rd_data.len == 11'd0) begin
                                r_status <= RES_NOTSTART;
                            end else begin
                                // first page cleared here, walk the rest
                                r_ov     <= 1'b0;
                                r_state  <= S_FREE;
                                r_in_use <= r_in_use - 1'b1;
                                r_idx    <= r_idx + 1'b1;
                                r_left   <= rd_data.len - 1'b1;
                            end
                        end
                        K_FIX, K_OWNER: begin
                            if (rd_free) begin
                                r_status <= RES_PAGEFREE;
                            end
                        end
                        K_QUERY: begin
                            if (!rd_free) begin
                                r_pstate <= rd_data.state;
                                r_oown   <= rd_data.owner;
                                r_ovp    <= rd_data.vpage;
                            end
                        end
                        default: begin
                            r_status <= RES_OK;
                        end
                    endcase
                end
                S_FREE: begin
                    if (free_done) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (!rd_free) begin
                            r_in_use <= r_in_use - 1'b1;
                        end
                        r_idx  <= r_idx + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_status;
    assign o_start_page = r_start;
    assign o_page_state = r_pstate;
    assign o_owner_out  = r_oown;
    assign o_vpage_out  = r_ovp;
    assign o_in_use     = 11'(r_in_use);

endmodule

`default_nettype wire

// File: hdl/page_frame_allocator.sv
// An alloc scan reads the page map one page read a cycle.
// Throughput: one operation at a time in the back end; a 2-entry queue takes
//   new transactions meanwhile.
// Reset: a clearing pass over all NUM_PAGES pages frees every page; input stalls until it ends.
`default_nettype none

module page_frame_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [10:0] i_count,
    input  wire logic [9:0]  i_page,
    input  wire logic        i_make_fixed,
    input  wire logic [15:0] i_owner,
    input  wire logic [19:0] i_vpage,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [9:0]       o_start_page,
    output logic [1:0]       o_page_state,
    output logic [15:0]      o_owner_out,
    output logic [19:0]      o_vpage_out,
    output logic [10:0]      o_in_use
);

    localparam int CW = ($clog2(NUM_PAGES + 1) > 11) ? $clog2(NUM_PAGES + 1) : 11;
    localparam logic [CW-1:0] NP = CW'(NUM_PAGES);

    logic [10:0]   r_total;
    logic [10:0]   r_reserved;
    logic [CW-1:0] size;
    logic [CW-1:0] res;
    logic          q_valid;
    logic          q_ready;
    logic          clearing;
    t_cmd          cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= 11'd1024;
            r_reserved <= 11'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOTAL:    r_total    <= i_cfg_data;
                CFG_RESERVED: r_reserved <= i_cfg_data;
                default:      r_total    <= r_total;
            endcase
        end
    end

    assign size = (CW'(r_total) < NP) ? CW'(r_total) : NP;
    assign res  = (CW'(r_reserved) < size) ? CW'(r_reserved) : size;

    pfa_front #(
        .CW(CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_count     (i_count),
        .i_page      (i_page),
        .i_make_fixed(i_make_fixed),
        .i_owner     (i_owner),
        .i_vpage     (i_vpage),
        .i_size      (size),
        .i_clearing  (clearing),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_cmd       (cmd)
    );

    pfa_back #(
        .NUM_PAGES(NUM_PAGES),
        .CW       (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (size),
        .i_res       (res),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_cmd       (cmd),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_start_page(o_start_page),
        .o_page_state(o_page_state),
        .o_owner_out (o_owner_out),
        .o_vpage_out (o_vpage_out),
        .o_in_use    (o_in_use)
    );

endmodule

`default_nettype wire

// File: tb/sv/page_frame_allocator_chk.sv
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Watches the command and result channels, keeps its own copy of the page map
// and compares every result transaction with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module page_frame_allocator_chk
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_op,
    input  logic [10:0] i_count,
    input  logic [9:0]  i_page,
    input  logic        i_make_fixed,
    input  logic [15:0] i_owner,
    input  logic [19:0] i_vpage,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [9:0]  i_start_page,
    input  logic [1:0]  i_page_state,
    input  logic [15:0] i_owner_out,
    input  logic [19:0] i_vpage_out,
    input  logic [10:0] i_in_use,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  start_page;
        logic [1:0]  page_state;
        logic [15:0] owner_out;
        logic [19:0] vpage_out;
        logic [10:0] in_use;
    } t_result;

    t_pstate     pg_state [NUM_PAGES];
    logic [10:0] pg_len   [NUM_PAGES];
    logic [15:0] pg_owner [NUM_PAGES];
    logic [19:0] pg_vpage [NUM_PAGES];
    int          cursor;
    int          used;
    int          total_reg;
    int          reserved_reg;
    t_result     expected_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic int find_run(int lo, int hi, int n);
        int run;
        run = 0;
        for (int i = lo; i < hi; i++) begin
            run = (pg_state[i] == ST_FREE) ? run + 1 : 0;
            if (run == n) return i;
        end
        return -1;
    endfunction

    function automatic t_result apply_op(logic [2:0] op, int cnt, int pg, logic mk,
                                         logic [15:0] own, logic [19:0] vp);
        t_result r;
        int size, res, last, first, n;
        bit inmap;
        r = '0;
        size = (total_reg < NUM_PAGES) ? total_reg : NUM_PAGES;
        inmap = pg < size;
        case (op)
            OP_INIT: begin
                res = (reserved_reg < size) ? reserved_reg : size;
                for (int i = 0; i < NUM_PAGES; i++) begin
                    pg_state[i] = (i < res) ? ST_FIXED : ST_FREE;
                    pg_len[i] = '0; pg_owner[i] = '0; pg_vpage[i] = '0;
                end
                used = res;
                cursor = 0;
            end
            OP_ALLOC: begin
                if (cnt == 0) begin
                    r.status = RES_BADCOUNT;
                end else begin
                    last = find_run(cursor, size, cnt);
                    if (last < 0) last = find_run(0, (cursor < size) ? cursor : size, cnt);
                    if (last < 0) begin
                        r.status = RES_NOSPACE;
                    end else begin
                        first = last + 1 - cnt;
                        for (int i = first; i <= last; i++) begin
                            pg_state[i] = ST_ALLOC;
                            pg_len[i] = '0; pg_owner[i] = '0; pg_vpage[i] = '0;
                        end
                        pg_len[first] = cnt;
                        used += cnt;
                        cursor = last;
                        r.start_page = first;
                    end
                end
            end
            OP_FREE: begin
                if (!inmap || pg_state[pg] == ST_FREE) begin
                    r.status = RES_PAGEFREE;
                end else if (pg_len[pg] == 0) begin
                    r.status = RES_NOTSTART;
                end else begin
                    n = pg_len[pg];
                    for (int i = 0; i < n && pg + i < size; i++) begin
                        if (pg_state[pg + i] != ST_FREE) begin
                            pg_state[pg + i] = ST_FREE;
                            pg_len[pg + i] = '0; pg_owner[pg + i] = '0;
                            pg_vpage[pg + i] = '0;
                            used--;
                        end
                    end
                end
            end
            OP_FIXED: begin
                if (!inmap || pg_state[pg] == ST_FREE) r.status = RES_PAGEFREE;
                else pg_state[pg] = mk ? ST_FIXED : ST_ALLOC;
            end
            OP_QUERY: begin
                if (inmap && pg_state[pg] != ST_FREE) begin
                    r.page_state = pg_state[pg];
                    r.owner_out = pg_owner[pg];
                    r.vpage_out = pg_vpage[pg];
                end
            end
            OP_OWNER: begin
                if (!inmap || pg_state[pg] == ST_FREE) begin
                    r.status = RES_PAGEFREE;
                end else begin
                    pg_owner[pg] = own;
                    pg_vpage[pg] = vp;
                end
            end
            default: ;
        endcase
        r.in_use = used;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
                pg_state[i] = ST_FREE;
                pg_len[i] = '0; pg_owner[i] = '0; pg_vpage[i] = '0;
            end
            cursor = 0; used = 0; total_reg = 1024; reserved_reg = 0;
            expected_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TOTAL) total_reg = i_cfg_data;
                else reserved_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_start_page, i_page_state, i_owner_out,
                        i_vpage_out, i_in_use};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result transaction %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t mismatch: status %0d/%0d start %0d/%0d state %0d/%0d owner %h/%h vpage %h/%h in_use %0d/%0d",
                                     $time, want.status, got.status, want.start_page,
                                     got.start_page, want.page_state, got.page_state,
                                     want.owner_out, got.owner_out, want.vpage_out,
                                     got.vpage_out, want.in_use, got.in_use);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(apply_op(i_op, i_count, i_page, i_make_fixed,
                                              i_owner, i_vpage));
        end
    end

endmodule

// File: tb/sv/page_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives directed and random page map operations through the block under
// several map sizes and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module page_frame_allocator_tb;
    import pfa_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TOTAL;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = OP_QUERY;
    logic [10:0] count = '0;
    logic [9:0]  page = '0;
    logic        make_fixed = 1'b0;
    logic [15:0] owner = '0;
    logic [19:0] vpage = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [9:0]  start_page;
    logic [1:0]  page_state;
    logic [15:0] owner_out;
    logic [19:0] vpage_out;
    logic [10:0] in_use;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 1'b0;
    int          map_pages = 1024;

    always #5 clk = ~clk;

    page_frame_allocator uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_count(count), .i_page(page), .i_make_fixed(make_fixed),
        .i_owner(owner), .i_vpage(vpage),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_start_page(start_page), .o_page_state(page_state),
        .o_owner_out(owner_out), .o_vpage_out(vpage_out), .o_in_use(in_use)
    );

    page_frame_allocator_chk checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_count(count), .i_page(page), .i_make_fixed(make_fixed),
        .i_owner(owner), .i_vpage(vpage),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_start_page(start_page), .i_page_state(page_state),
        .i_owner_out(owner_out), .i_vpage_out(vpage_out), .i_in_use(in_use),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, plus a long hold-off on request
    always @(negedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(logic idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // hold valid low for one cycle before the next write
        @(negedge clk);
    endtask

    // offer one transaction; valid stays high across back-to-back items
    task automatic send_op(logic [2:0] o, int c, int p, logic mk = 1'b0,
                           logic [15:0] ow = '0, logic [19:0] vp = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o; count <= 11'(c); page <= 10'(p); make_fixed <= mk;
        owner <= ow; vpage <= vp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2200) @(negedge clk);
    endtask

    task automatic set_map(int total, int reserved);
        write_reg(CFG_TOTAL, 11'(total));
        write_reg(CFG_RESERVED, 11'(reserved));
        map_pages = (total < 1024) ? total : 1024;
    endtask

    // mostly small allocations, with frees and page ops at random pages
    task automatic random_ops(int n);
        int blocks[$];
        int r, p;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            p = (map_pages > 0 && $urandom_range(9) != 0) ?
                $urandom_range(map_pages - 1) : $urandom_range(1023);
            if (r < 2) begin
                send_op(OP_INIT, $urandom_range(2047), p);
                blocks.delete();
            end else if (r < 35) begin
                send_op(OP_ALLOC, ($urandom_range(19) == 0) ? $urandom_range(2047)
                        : $urandom_range(1, 24), p);
                if (blocks.size() < 64) blocks.push_back(-1);
            end else if (r < 55) begin
                send_op(OP_FREE, $urandom_range(2047), p);
            end else if (r < 68) begin
                send_op(OP_FIXED, $urandom_range(2047), p, $urandom_range(1));
            end else if (r < 84) begin
                send_op(OP_QUERY, $urandom_range(2047), p);
            end else if (r < 98) begin
                send_op(OP_OWNER, $urandom_range(2047), p, $urandom_range(1),
                        $urandom_range(65535), $urandom_range(1048575));
            end else begin
                send_op($urandom_range(6, 7), $urandom_range(2047), p);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset registers, alloc before init
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 3, 0);
        send_op(OP_QUERY, 0, 0);
        send_op(OP_QUERY, 0, 1023);
        send_op(6, 0, 0);
        send_op(7, 2047, 1023, 1'b1, 16'hffff, 20'hfffff);
        drain();
        set_map(16, 4);
        send_op(OP_INIT, 0, 0);
        send_op(OP_QUERY, 0, 3);
        send_op(OP_FREE, 0, 3);
        send_op(OP_ALLOC, 5, 0);
        send_op(OP_ALLOC, 5, 0);
        send_op(OP_ALLOC, 5, 0);
        send_op(OP_ALLOC, 2047, 0);
        send_op(OP_FREE, 0, 5);
        send_op(OP_FREE, 0, 4);
        send_op(OP_FREE, 0, 4);
        send_op(OP_ALLOC, 3, 0);
        send_op(OP_OWNER, 0, 9, 1'b0, 16'hffff, 20'hfffff);
        send_op(OP_QUERY, 0, 9);
        send_op(OP_FIXED, 0, 9, 1'b1);
        send_op(OP_FIXED, 0, 9, 1'b0);
        send_op(OP_OWNER, 0, 15, 1'b0, 16'h1234, 20'h5);
        send_op(OP_OWNER, 0, 1023, 1'b0, 16'h1, 20'h1);
        send_op(OP_FREE, 0, 1023);
        send_op(OP_FIXED, 0, 1023, 1'b1);
        drain();
        // total 0, reserved above total, full 1024 with full reservation
        set_map(0, 5);
        send_op(OP_INIT, 0, 0);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_QUERY, 0, 0);
        drain();
        set_map(2047, 2047);
        send_op(OP_INIT, 0, 0);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_QUERY, 0, 1023);
        drain();

        // random phases across map settings and idle patterns
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin set_map(64, 0);    send_idle_pct = 0;  stall_pct = 0;  end
                1: begin set_map(40, 3);    send_idle_pct = 69; stall_pct = 0;  end
                2: begin set_map(128, 10);  send_idle_pct = 0;  stall_pct = 69; end
                3: begin set_map(1024, 0);  send_idle_pct = 21; stall_pct = 21; end
                default: begin set_map(1, 1); send_idle_pct = 0; stall_pct = 0; end
            endcase
            send_op(OP_INIT, 0, 0);
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    random_ops(20);
                join
            end
            random_ops(ph == 4 ? 30 : 115);
            drain();
        end

        if (fail_count == 0)
            $display("page_frame_allocator regression: pass");
        else
            $display("page_frame_allocator regression: fail");
        $finish;
    end

    initial begin
        #50ms;
        $display("page_frame_allocator regression: fail");
        $finish;
    end

endmodule
